FILE: hdl/ptmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed triangular matrix-vector core: shared definitions
// Field widths, command and register codes, multiply modes and the payload
// types of the request, response and internal pipeline tag.
// ----------------------------------------------------------------------------
package ptmv_pkg;

   localparam int MAX_ORDER_DEFAULT  = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_WIDTH      = 2;
   localparam int INDEX_WIDTH    = 12;
   localparam int VALUE_WIDTH    = 32;
   localparam int ROW_WIDTH      = 6;
   localparam int RESULT_WIDTH   = 64;
   localparam int LENGTH_WIDTH   = 7;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 7;

   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_MATRIX = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_VECTOR = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_START       = 2'd2;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_LOWER_MODE     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_TRANSPOSE_MODE = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VECTOR_LENGTH  = 2'd2;

   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = 7'd64;

   // Mode code is {lower_mode, transpose_mode}.
   localparam logic [1:0] MODE_UPPER_PLAIN = 2'b00;
   localparam logic [1:0] MODE_UPPER_TRANS = 2'b01;
   localparam logic [1:0] MODE_LOWER_PLAIN = 2'b10;
   localparam logic [1:0] MODE_LOWER_TRANS = 2'b11;

   localparam logic signed [RESULT_WIDTH-1:0] RESULT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [RESULT_WIDTH-1:0] RESULT_MIN = 64'sh8000_0000_0000_0000;

   typedef logic [ROW_WIDTH-1:0] row_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]          command;
      logic [INDEX_WIDTH-1:0]        index;
      logic signed [VALUE_WIDTH-1:0] value;
   } ptmv_req_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]           row_index;
      logic signed [RESULT_WIDTH-1:0] result_value;
      logic                           last;
   } ptmv_rsp_type;

   typedef struct packed {
      logic    first;
      logic    last;
      logic    final_row;
      row_type row;
   } ptmv_tag_type;

endpackage

FILE: hdl/packed_triangular_matvec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed triangular matrix-vector core
// Load transactions fill the packed matrix and vector memories; a start
// transaction walks the stored triangle and returns one saturated Q32.32 row
// sum per element of the result vector, the last one marked.
// ----------------------------------------------------------------------------
// A load transaction may be followed by the next one at once. A start
// transaction issues one multiply-accumulate per cycle, reading one matrix
// word and one vector word through the single read port of each memory,
// and holds the request side until the last term of the walk is read; each
// row sum passes through the memory read registers, the product register
// and the response register after the read of its last term. The next
// transaction is taken in the cycle after the last read. A stalled response
// channel holds the walk in place. The memories need no clearing pass after
// reset if the user writes every entry before it is read; the block does not check.
module packed_triangular_matvec_core #(
   parameter int MAX_ORDER  = ptmv_pkg::MAX_ORDER_DEFAULT,
   parameter int DATA_WIDTH = ptmv_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ptmv_pkg::ptmv_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ptmv_pkg::ptmv_rsp_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ptmv_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [ptmv_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int PACKED_DEPTH = (MAX_ORDER * (MAX_ORDER + 1)) / 2;
   localparam int AW = (PACKED_DEPTH > 1) ? $clog2(PACKED_DEPTH) : 1;
   localparam int VW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   logic                                lower_mode_ff;
   logic                                transpose_mode_ff;
   logic [ptmv_pkg::LENGTH_WIDTH-1:0]   vector_length_ff;

   logic [DATA_WIDTH-1:0]               mat_mem [PACKED_DEPTH];
   logic [DATA_WIDTH-1:0]               vec_mem [MAX_ORDER];
   logic signed [DATA_WIDTH-1:0]        mat_rd_ff;
   logic signed [DATA_WIDTH-1:0]        vec_rd_ff;

   logic                                busy_ff, busy_in;
   logic                                first_ff, first_in;
   logic [1:0]                          mode_ff, mode_in;
   logic [VW-1:0]                       e_ff, e_in;
   logic [VW-1:0]                       i_ff, i_in;
   logic [VW-1:0]                       nm1_ff, nm1_in;
   logic [AW-1:0]                       addr_ff, addr_in;
   logic [AW-1:0]                       diag_ff, diag_in;

   logic                                s1_valid_ff, s2_valid_ff;
   ptmv_pkg::ptmv_tag_type              s1_tag_ff, s2_tag_ff, issue_tag;
   logic signed [2*DATA_WIDTH-1:0]      product;
   logic signed [63:0]                  prod_ff;
   logic signed [63:0]                  acc_ff;
   logic signed [63:0]                  acc_base;
   logic signed [64:0]                  sum_wide;
   logic signed [63:0]                  sat_sum;
   logic                                rsp_valid_ff, rsp_valid_in;
   ptmv_pkg::ptmv_rsp_type              rsp_data_ff;

   logic                                req_fire;
   logic                                adv;
   logic                                issue;
   logic                                mat_we, vec_we, start;
   logic [31:0]                         idx_wide;
   logic [31:0]                         n_clamped;
   logic                                step_last;
   logic [VW-1:0]                       nxt_i;
   logic [AW-1:0]                       nxt_addr, nxt_diag;
   logic [AW-1:0]                       iw, ew, nw;

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign adv       = !(rsp_valid_ff && !rsp_ready);
   assign issue     = busy_ff && adv;
   assign idx_wide  = 32'(req_data.index);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_mode_ff     <= 1'b0;
         transpose_mode_ff <= 1'b0;
         vector_length_ff  <= ptmv_pkg::LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ptmv_pkg::REG_LOWER_MODE:     lower_mode_ff     <= csr_wdata[0];
            ptmv_pkg::REG_TRANSPOSE_MODE: transpose_mode_ff <= csr_wdata[0];
            ptmv_pkg::REG_VECTOR_LENGTH:  vector_length_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mat_we = 1'b0;
      vec_we = 1'b0;
      start  = 1'b0;
      if (req_fire) begin
         unique case (req_data.command)
            ptmv_pkg::CMD_LOAD_MATRIX: mat_we = idx_wide < 32'(PACKED_DEPTH);
            ptmv_pkg::CMD_LOAD_VECTOR: vec_we = idx_wide < 32'(MAX_ORDER);
            ptmv_pkg::CMD_START:       start  = vector_length_ff != '0;
            default: ;
         endcase
      end
   end

   assign n_clamped = (32'(vector_length_ff) > 32'(MAX_ORDER)) ? 32'(MAX_ORDER)
                                                               : 32'(vector_length_ff);

   // Next read position within the triangle for each walk order.
   always_comb begin
      iw        = AW'(i_ff);
      ew        = AW'(e_ff);
      nw        = AW'(nm1_ff);
      step_last = 1'b0;
      nxt_i     = i_ff + VW'(1);
      nxt_addr  = addr_ff + AW'(1);
      nxt_diag  = diag_ff;
      unique case (mode_ff)
         ptmv_pkg::MODE_UPPER_PLAIN: begin
            step_last = i_ff == nm1_ff;
            if (step_last) begin
               nxt_i = e_ff + VW'(1);
            end
         end
         ptmv_pkg::MODE_LOWER_PLAIN: begin
            step_last = i_ff == e_ff;
            if (step_last) begin
               nxt_i = '0;
            end
         end
         ptmv_pkg::MODE_UPPER_TRANS: begin
            step_last = i_ff == '0;
            if (step_last) begin
               nxt_i    = e_ff + VW'(1);
               nxt_diag = diag_ff + nw - ew + AW'(1);
               nxt_addr = nxt_diag;
            end else begin
               nxt_i    = i_ff - VW'(1);
               nxt_addr = addr_ff - (nw - iw + AW'(1));
            end
         end
         default: begin
            step_last = i_ff == nm1_ff;
            if (step_last) begin
               nxt_i    = e_ff + VW'(1);
               nxt_diag = diag_ff + ew + AW'(2);
               nxt_addr = nxt_diag;
            end else begin
               nxt_addr = addr_ff + iw + AW'(1);
            end
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      first_in = first_ff;
      mode_in  = mode_ff;
      e_in     = e_ff;
      i_in     = i_ff;
      nm1_in   = nm1_ff;
      addr_in  = addr_ff;
      diag_in  = diag_ff;
      if (start) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         mode_in  = {lower_mode_ff, transpose_mode_ff};
         e_in     = '0;
         i_in     = '0;
         addr_in  = '0;
         diag_in  = '0;
         nm1_in   = VW'(n_clamped - 32'd1);
      end else if (issue) begin
         first_in = step_last;
         i_in     = nxt_i;
         addr_in  = nxt_addr;
         diag_in  = nxt_diag;
         if (step_last) begin
            e_in = e_ff + VW'(1);
            if (e_ff == nm1_ff) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      first_ff <= first_in;
      mode_ff  <= mode_in;
      e_ff     <= e_in;
      i_ff     <= i_in;
      nm1_ff   <= nm1_in;
      addr_ff  <= addr_in;
      diag_ff  <= diag_in;
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[idx_wide[AW-1:0]] <= req_data.value[DATA_WIDTH-1:0];
      end
      if (issue) begin
         mat_rd_ff <= mat_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[idx_wide[VW-1:0]] <= req_data.value[DATA_WIDTH-1:0];
      end
      if (issue) begin
         vec_rd_ff <= vec_mem[i_ff];
      end
   end

   assign issue_tag.first     = first_ff;
   assign issue_tag.last      = step_last;
   assign issue_tag.final_row = e_ff == nm1_ff;
   assign issue_tag.row       = ptmv_pkg::row_type'(e_ff);

   assign product  = mat_rd_ff * vec_rd_ff;
   assign acc_base = s2_tag_ff.first ? 64'sd0 : acc_ff;
   assign sum_wide = 65'(acc_base) + 65'(prod_ff);

   always_comb begin
      sat_sum = sum_wide[63:0];
      if (sum_wide[64] != sum_wide[63]) begin
         sat_sum = sum_wide[64] ? ptmv_pkg::RESULT_MIN : ptmv_pkg::RESULT_MAX;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (adv && s2_valid_ff && s2_tag_ff.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            s1_valid_ff <= busy_ff;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff <= issue_tag;
         s2_tag_ff <= s1_tag_ff;
         prod_ff   <= 64'(product);
         if (s2_valid_ff) begin
            acc_ff <= sat_sum;
         end
         if (s2_valid_ff && s2_tag_ff.last) begin
            rsp_data_ff.row_index    <= s2_tag_ff.row;
            rsp_data_ff.result_value <= sat_sum;
            rsp_data_ff.last         <= s2_tag_ff.final_row;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (32'(addr_ff) < 32'(PACKED_DEPTH)))
      else $error("Matrix read address beyond the packed triangle.");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (i_ff <= nm1_ff && e_ff <= nm1_ff))
      else $error("Walk position beyond the vector length in use.");

   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !adv) |=> ($stable(addr_ff) && $stable(i_ff) && $stable(e_ff)))
      else $error("Triangle walk moved while the response side was stalled.");

   assert property (@(posedge clock) disable iff (reset)
      (adv && !busy_ff) |=> !s1_valid_ff)
      else $error("Memory read stage filled without an active walk.");

endmodule
